// ----- sv/smm_pkg.sv -----
// smm_pkg: shared types and constants of the segmented memory mapper
// used by smm_map_table, smm_phys_mem and segmented_memory_mapper
// no dependencies
`default_nettype none

package smm_pkg;

	// fixed geometry of the 16-bit logical address
	localparam int SLOTS         = 16;
	localparam int SLOT_W        = 4;
	localparam int OFFSET_W      = 12;
	localparam int SEGMENT_WORDS = 4096;
	localparam int WORD_W        = 16;
	localparam int BLOCK_W       = 4;
	localparam int MOD_W         = 2;
	localparam int SEG_W         = 4;
	localparam int COUNT_W       = 5;

	// modules addressable by the 2-bit module field, one count register each
	localparam int CFG_REGS    = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_MODULES = 4;

	// parameter defaults
	localparam int NUM_BLOCKS_DEF          = 16;
	localparam int NUM_MODULES_DEF         = 4;
	localparam int SEGMENTS_PER_MODULE_DEF = 16;

	localparam logic [WORD_W-1:0] FAIL_WORD = 16'hdead;

	localparam logic [COUNT_W-1:0] SEG_COUNT_RST [CFG_REGS] =
		'{5'd2, 5'd8, 5'd8, 5'd0};

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_MAP    = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 operation;
		logic [BLOCK_W-1:0]  block;
		logic [WORD_W-1:0]   address;
		logic [WORD_W-1:0]   write_data;
		logic [SLOT_W-1:0]   slot;
		logic [MOD_W-1:0]    module_req;
		logic [SEG_W-1:0]    segment;
		logic                user_mode;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              status;
		logic              no_mem_interrupt;
	} rsp_t;

	// physical location named by a map entry
	typedef struct packed {
		logic [MOD_W-1:0] mod_idx;
		logic [SEG_W-1:0] seg_idx;
	} map_loc_t;

	typedef struct packed {
		logic     valid;
		map_loc_t loc;
	} map_entry_t;

	// update command for the map table
	typedef struct packed {
		logic                wr;
		logic                clr;
		logic [BLOCK_W-1:0]  block;
		logic [SLOT_W-1:0]   slot;
		logic                valid;
		map_loc_t            loc;
	} map_cmd_t;

endpackage

`default_nettype wire

// ----- sv/segmented_memory_mapper.sv -----
// segmented_memory_mapper: top level, request pipeline, count registers
// instantiates smm_map_table and smm_phys_mem
// depends on smm_pkg
`default_nettype none

// segmented memory unit of a 16-bit machine. a request (read, write, map,
// remove-all) is taken at a clock edge where start is high and busy is low.
// its result word is registered through stage 1 and stage 2 and appears
// on rsp for exactly one cycle with done high; it is not held, so the
// receiver must take it then. busy is high while a request is in stage 1,
// so a new request is taken only after the last one has left
// the map table read, which must complete before the physical word memory can
// be addressed. the count registers are written through cfg_valid/cfg_ready
// (always ready) and should only be changed while no request is in flight.
// failed reads return 0xdead with status set; no_mem_interrupt follows
// user_mode on a failed access.
// reading a physical word that was never written returns an arbitrary value.
module segmented_memory_mapper #(
	parameter int NUM_BLOCKS          = smm_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_MODULES         = smm_pkg::NUM_MODULES_DEF,
	parameter int SEGMENTS_PER_MODULE = smm_pkg::SEGMENTS_PER_MODULE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire smm_pkg::req_t                   req,
	output logic                                 done,
	output smm_pkg::rsp_t                        rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [smm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [smm_pkg::COUNT_W-1:0]     cfg_data
);
	import smm_pkg::*;

	// physical store covers only the modules the 2-bit field can reach
	localparam int PHYS_MODS = (NUM_MODULES < MAX_MODULES) ? NUM_MODULES : MAX_MODULES;
	localparam int PHYS_SEGS = PHYS_MODS * SEGMENTS_PER_MODULE;
	localparam int SEG_AW    = (PHYS_SEGS > 1) ? $clog2(PHYS_SEGS) : 1;
	localparam int PHYS_AW   = SEG_AW + OFFSET_W;
	localparam int PHYS_DEPTH = PHYS_SEGS * SEGMENT_WORDS;

	// segment count per module
	logic [COUNT_W-1:0] seg_count_q [CFG_REGS];

	// stage 1: map entry being read, stage 2: result word
	logic               valid_s1;
	req_t               req_s1;
	logic               valid_s2;
	op_t                op_s2;
	logic               status_s2;
	logic               irq_s2;

	logic               accept;
	map_entry_t         entry;
	map_cmd_t           map_cmd;
	logic               blk_ok;
	logic               acc_ok;
	logic               map_ok;
	logic               is_access;
	logic               status_d;
	logic [7:0]         seg_lin;
	logic [PHYS_AW-1:0] phys_addr;
	logic               phys_we;
	logic               phys_re;
	logic [WORD_W-1:0]  phys_rdata;

	// segment present in its module under the current counts
	function automatic logic seg_present(
		input logic [MOD_W-1:0]   m,
		input logic [SEG_W-1:0]   s,
		input logic [COUNT_W-1:0] cnt
	);
		seg_present = (COUNT_W'(m) < COUNT_W'(NUM_MODULES))
		           && (COUNT_W'(s) < COUNT_W'(SEGMENTS_PER_MODULE))
		           && (COUNT_W'(s) < cnt);
	endfunction

	assign accept    = start && !busy;
	assign busy      = valid_s1;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				seg_count_q[i] <= SEG_COUNT_RST[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			seg_count_q[cfg_index] <= cfg_data;
		end
	end

	// the map lookup uses the slot bits of the logical address
	smm_map_table #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_block (req.block),
		.rd_slot  (req.address[WORD_W-1 -: SLOT_W]),
		.cmd      (map_cmd),
		.entry    (entry)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// translation and presence check on the fetched entry
	always_comb begin
		blk_ok    = {1'b0, req_s1.block} < (BLOCK_W + 1)'(NUM_BLOCKS);
		is_access = (req_s1.operation == OP_READ) || (req_s1.operation == OP_WRITE);
		acc_ok    = blk_ok && entry.valid
		         && seg_present(entry.loc.mod_idx, entry.loc.seg_idx,
		                        seg_count_q[entry.loc.mod_idx]);
		map_ok    = seg_present(req_s1.module_req, req_s1.segment,
		                        seg_count_q[req_s1.module_req]);
		seg_lin   = 8'(entry.loc.mod_idx) * 8'(SEGMENTS_PER_MODULE)
		          + 8'(entry.loc.seg_idx);
		phys_addr = {SEG_AW'(seg_lin), req_s1.address[OFFSET_W-1:0]};
	end

	// map updates land before the next request's lookup
	always_comb begin
		map_cmd.wr          = valid_s1 && (req_s1.operation == OP_MAP) && blk_ok;
		map_cmd.clr         = valid_s1 && (req_s1.operation == OP_REMOVE);
		map_cmd.block       = req_s1.block;
		map_cmd.slot        = req_s1.slot;
		map_cmd.valid       = map_ok;
		map_cmd.loc.mod_idx = req_s1.module_req;
		map_cmd.loc.seg_idx = req_s1.segment;
	end

	always_comb begin
		unique case (req_s1.operation)
			OP_READ, OP_WRITE: status_d = !acc_ok;
			OP_MAP:            status_d = !(blk_ok && map_ok);
			OP_REMOVE:         status_d = 1'b0;
			default:           status_d = 1'b0;
		endcase
	end

	assign phys_we = valid_s1 && (req_s1.operation == OP_WRITE) && acc_ok;
	assign phys_re = valid_s1 && (req_s1.operation == OP_READ) && acc_ok;

	smm_phys_mem #(
		.ADDR_W (PHYS_AW),
		.DEPTH  (PHYS_DEPTH)
	) u_phys (
		.clk   (clk),
		.we    (phys_we),
		.re    (phys_re),
		.addr  (phys_addr),
		.wdata (req_s1.write_data),
		.rdata (phys_rdata)
	);

	// stage 2: result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			op_s2     <= req_s1.operation;
			status_s2 <= status_d;
			irq_s2    <= is_access && !acc_ok && req_s1.user_mode;
		end
	end

	assign done = valid_s2;

	always_comb begin
		rsp.status           = status_s2;
		rsp.no_mem_interrupt = irq_s2;
		if (op_s2 == OP_READ) begin
			rsp.read_data = status_s2 ? FAIL_WORD : phys_rdata;
		end else begin
			rsp.read_data = '0;
		end
	end

`ifndef ASSERT_OFF
	// every accepted request yields its word through stage 1 and then stage 2
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result word missing after accepted request");

	// at most one request in flight between lookup and result
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("two requests overlap in the pipeline");

	// map write and remove-all never collide on the valid bits
	a_map_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(map_cmd.wr && map_cmd.clr))
		else $error("map write and remove-all in the same cycle");

	// an interrupt only accompanies a failed access
	a_irq_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.no_mem_interrupt) |-> (rsp.status && op_s2 != OP_MAP
			&& op_s2 != OP_REMOVE))
		else $error("interrupt without failed access");
`endif

endmodule

`default_nettype wire

// ----- sv/smm_map_table.sv -----
// smm_map_table: block/slot to physical segment map, registered read
// synchronous memory for locations, flip-flop valid bits, block 0 reset image
// depends on smm_pkg
`default_nettype none

module smm_map_table #(
	parameter int NUM_BLOCKS = smm_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [smm_pkg::BLOCK_W-1:0]  rd_block,
	input  wire logic [smm_pkg::SLOT_W-1:0]   rd_slot,
	input  wire smm_pkg::map_cmd_t            cmd,
	output smm_pkg::map_entry_t               entry
);
	import smm_pkg::*;

	localparam int MAP_DEPTH = NUM_BLOCKS * SLOTS;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	map_loc_t               mem [MAP_DEPTH];
	map_loc_t               mem_rd_q;
	logic [BLOCK_W-1:0]     rd_block_q;
	logic [SLOT_W-1:0]      rd_slot_q;
	logic [MAP_DEPTH-1:0]   valid_q;
	logic [SLOTS-1:0]       b0_written_q;
	logic [MAP_AW-1:0]      rd_idx;
	logic [MAP_AW-1:0]      rd_idx_q;
	logic [MAP_AW-1:0]      wr_idx;
	map_loc_t               b0_image;

	assign rd_idx   = MAP_AW'({rd_block, rd_slot});
	assign rd_idx_q = MAP_AW'({rd_block_q, rd_slot_q});
	assign wr_idx   = MAP_AW'({cmd.block, cmd.slot});

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_idx] <= cmd.loc;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_idx];
			rd_block_q <= rd_block;
			rd_slot_q  <= rd_slot;
		end
	end

	// block 0 starts valid, all others invalid; remove-all spares block 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= MAP_DEPTH'({SLOTS{1'b1}});
		end else if (cmd.clr) begin
			for (int i = SLOTS; i < MAP_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (cmd.wr) begin
			valid_q[wr_idx] <= cmd.valid;
		end
	end

	// block 0 entries read as identity until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_written_q <= '0;
		end else if (cmd.wr && cmd.block == '0) begin
			b0_written_q[cmd.slot] <= 1'b1;
		end
	end

	always_comb begin
		b0_image.mod_idx = '0;
		b0_image.seg_idx = SEG_W'(rd_slot_q);
	end

	always_comb begin
		entry.valid = valid_q[rd_idx_q];
		if (rd_block_q == '0 && !b0_written_q[rd_slot_q]) begin
			entry.loc = b0_image;
		end else begin
			entry.loc = mem_rd_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/smm_phys_mem.sv -----
// smm_phys_mem: physical word store, one write or one read a cycle
// synchronous memory with registered read data, no reset
// depends on smm_pkg
`default_nettype none

module smm_phys_mem #(
	parameter int ADDR_W = 18,
	parameter int DEPTH  = 262144
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic                        re,
	input  wire logic [ADDR_W-1:0]           addr,
	input  wire logic [smm_pkg::WORD_W-1:0]  wdata,
	output logic [smm_pkg::WORD_W-1:0]       rdata
);
	import smm_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
